@@ hw/rtl/lxkc_pkg.sv @@
// lxkc_pkg: shared types and constants for the lagged-XOR keystream cipher.
// No dependencies.
package lxkc_pkg;
   localparam int unsigned WORD_W = 32;
   localparam logic [31:0] LCG_MUL = 32'h5D588B65;
   localparam logic [31:0] HI_MASK = 32'hFF800000;
   localparam logic [31:0] LO_MASK = 32'h007FFFFF;

   typedef enum logic {
      CMD_REBUILD = 1'b0,
      CMD_CRYPT   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LCG,
      OP_REC,
      OP_MIX,
      OP_CRYPT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [9:0]  idx;
      logic        first;
      logic [1:0]  ph;
   } dp_cmd_type;
endpackage

@@ hw/rtl/lxkc_datapath.sv @@
// lxkc_datapath: key table memory, LCG, recurrence and mix arithmetic.
// Depends on lxkc_pkg.
module lxkc_datapath #(
   parameter int unsigned TABLE_WORDS = 521
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lxkc_pkg::dp_cmd_type cmd,
   input  logic [31:0]          seed,
   input  logic [31:0]          data_word,
   output logic [31:0]          key_word
);
   localparam int unsigned AW = $clog2(TABLE_WORDS);

   logic [31:0] mem [TABLE_WORDS];
   logic [31:0] s_ff, s_in, acc_ff, acc_in, prod_ff;
   logic [31:0] a_ff, b_ff, key_ff;
   logic [AW-1:0] ra, wa;
   logic [31:0] rdat_ff, wdat;
   logic        we;

   // Multi-read ops run in phases given by the controller; the last read
   // is used straight from the memory output register.
   assign key_word = key_ff;
   assign s_in  = prod_ff + 32'd1;
   assign acc_in = {s_in[31], acc_ff[31:1]};

   always_comb begin
      ra = cmd.idx[AW-1:0];
      we = 1'b0;
      wa = cmd.idx[AW-1:0];
      wdat = '0;
      case (cmd.op)
         lxkc_pkg::OP_LCG: begin
            we = (cmd.ph == 2'd3);
            wdat = acc_ff;
         end
         lxkc_pkg::OP_REC: begin
            // idx=i: reads i-17, i-16, i-1
            unique case (cmd.ph)
               2'd0: ra = AW'(cmd.idx - 10'd17);
               2'd1: ra = AW'(cmd.idx - 10'd16);
               default: ra = AW'(cmd.idx - 10'd1);
            endcase
            we = (cmd.ph == 2'd3);
            wdat = rdat_ff ^ ((a_ff << 23) & lxkc_pkg::HI_MASK)
                   ^ ((b_ff >> 9) & lxkc_pkg::LO_MASK);
         end
         lxkc_pkg::OP_MIX: begin
            ra = (cmd.ph == 2'd0) ? cmd.idx[AW-1:0]
               : ((cmd.idx < 10'd32) ? AW'(cmd.idx + 10'(TABLE_WORDS - 32))
                                    : AW'(cmd.idx - 10'd32));
            we = (cmd.ph == 2'd3);
            wdat = a_ff ^ b_ff;
         end
         lxkc_pkg::OP_NONE: begin
            // word 16 fixup uses first flag: reads 0, 16, 15
            if (cmd.first) begin
               unique case (cmd.ph)
                  2'd0: ra = AW'(0);
                  2'd1: ra = AW'(16);
                  default: ra = AW'(15);
               endcase
               we = (cmd.ph == 2'd3);
               wa = AW'(16);
               wdat = (a_ff >> 9) ^ (b_ff << 23) ^ rdat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rdat_ff <= mem[ra];
      if (we) mem[wa] <= wdat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else begin
         if (cmd.op == lxkc_pkg::OP_NONE && !cmd.first) s_ff <= seed;
         else if (cmd.op == lxkc_pkg::OP_LCG && cmd.ph == 2'd1) s_ff <= s_in;
      end
      if (cmd.op == lxkc_pkg::OP_LCG) begin
         // ph0: product, ph1: step done -> shift
         if (cmd.ph == 2'd0) prod_ff <= s_ff * lxkc_pkg::LCG_MUL;
         if (cmd.ph == 2'd1) acc_ff <= acc_in;
      end
      if (cmd.ph == 2'd1) a_ff <= rdat_ff;
      if (cmd.ph == 2'd2) b_ff <= rdat_ff;
      if (cmd.op == lxkc_pkg::OP_CRYPT && cmd.ph == 2'd1) key_ff <= rdat_ff ^ data_word;
   end
endmodule

@@ hw/rtl/lxkc_ctrl.sv @@
// lxkc_ctrl: sequencer for rebuild, mix passes and crypt items.
// Depends on lxkc_pkg.
module lxkc_ctrl #(
   parameter int unsigned TABLE_WORDS = 521
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lxkc_pkg::cmd_type     command,
   output lxkc_pkg::dp_cmd_type  dcmd,
   output logic                  busy,
   output logic                  done
);
   typedef enum logic [2:0] {
      S_IDLE, S_LCG, S_FIX, S_REC, S_MIX, S_CRYPT
   } state_type;

   state_type   state_ff;
   logic [9:0]  idx_ff, pos_ff;
   logic [5:0]  bit_ff;
   logic [1:0]  ph_ff, mixes_ff;
   logic        crypt_ff;

   always_comb begin
      dcmd.op = lxkc_pkg::OP_NONE;
      dcmd.idx = idx_ff;
      dcmd.first = 1'b0;
      dcmd.ph = ph_ff;
      unique case (state_ff)
         S_LCG: begin
            dcmd.op = lxkc_pkg::OP_LCG;
            dcmd.first = 1'b1;
         end
         S_FIX: dcmd.first = 1'b1;
         S_REC: dcmd.op = lxkc_pkg::OP_REC;
         S_MIX: dcmd.op = lxkc_pkg::OP_MIX;
         S_CRYPT: dcmd.op = lxkc_pkg::OP_CRYPT;
         default: ;
      endcase
   end
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= 10'(TABLE_WORDS - 1);
         done <= 1'b0;
         idx_ff <= '0;
         ph_ff <= '0;
         bit_ff <= '0;
         mixes_ff <= '0;
         crypt_ff <= 1'b0;
      end else begin
         done <= 1'b0;
         ph_ff <= ph_ff + 2'd1;
         unique case (state_ff)
            S_IDLE: begin
               ph_ff <= '0;
               if (start) begin
                  if (command == lxkc_pkg::CMD_REBUILD) begin
                     state_ff <= S_LCG;
                     idx_ff <= '0;
                     bit_ff <= '0;
                     crypt_ff <= 1'b0;
                  end else if (pos_ff == 10'(TABLE_WORDS - 1)) begin
                     state_ff <= S_MIX;
                     idx_ff <= '0;
                     mixes_ff <= 2'd2;
                     crypt_ff <= 1'b1;
                     pos_ff <= '0;
                  end else begin
                     state_ff <= S_CRYPT;
                     pos_ff <= pos_ff + 10'd1;
                     idx_ff <= pos_ff + 10'd1;
                  end
               end
            end
            S_LCG: if (ph_ff == 2'd1) begin
               bit_ff <= bit_ff + 6'd1;
               if (bit_ff != 6'd31) ph_ff <= '0;
            end else if (ph_ff == 2'd3) begin
               bit_ff <= '0;
               ph_ff <= '0;
               if (idx_ff == 10'd16) state_ff <= S_FIX;
               else idx_ff <= idx_ff + 10'd1;
            end
            S_FIX: if (ph_ff == 2'd3) begin
               state_ff <= S_REC;
               idx_ff <= 10'd17;
            end
            S_REC: if (ph_ff == 2'd3) begin
               if (idx_ff == 10'(TABLE_WORDS - 1)) begin
                  state_ff <= S_MIX;
                  idx_ff <= '0;
                  mixes_ff <= '0;
               end else idx_ff <= idx_ff + 10'd1;
            end
            S_MIX: if (ph_ff == 2'd3) begin
               if (idx_ff == 10'(TABLE_WORDS - 1)) begin
                  idx_ff <= '0;
                  if (mixes_ff == 2'd2) begin
                     if (crypt_ff) state_ff <= S_CRYPT;
                     else begin
                        state_ff <= S_IDLE;
                        pos_ff <= 10'(TABLE_WORDS - 1);
                        done <= 1'b1;
                     end
                  end else mixes_ff <= mixes_ff + 2'd1;
               end else idx_ff <= idx_ff + 10'd1;
            end
            S_CRYPT: if (ph_ff == 2'd2) begin
               state_ff <= S_IDLE;
               done <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ hw/rtl/lagged_xor_keystream_cipher.sv @@
// Lagged-XOR keystream cipher top level: controller, datapath, output register.
// Depends on lxkc_pkg, lxkc_ctrl, lxkc_datapath. One item in flight at a time.
// Crypt item: result valid after the table read, key and done registers; next item taken
// only once the result is taken; every 521st item first runs a mix pass over the table.
// Rebuild: LCG fill of words 0-16, word 16 fixup, recurrence, three mix passes; result then registered.
// Synchronous reset clears control state; the key table is undefined until rebuilt.
module lagged_xor_keystream_cipher #(
   parameter int unsigned TABLE_WORDS = 521
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_key_seed,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_data_word,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_data_out,
   output logic        rsp_last_out
);
   logic [31:0] seed_ff, data_ff;
   logic        cmd_ff, last_ff, held_ff;
   logic        busy, done, start;
   logic [31:0] key_word;
   lxkc_pkg::dp_cmd_type dcmd;

   assign csr_ready = 1'b1;
   assign req_stall = busy || held_ff;
   assign start = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         held_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid) seed_ff <= csr_key_seed;
         if (start) held_ff <= 1'b1;
         if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
            held_ff <= 1'b0;
         end
         if (done) rsp_valid <= 1'b1;
      end
      if (start) begin
         cmd_ff <= req_command;
         data_ff <= req_data_word;
         last_ff <= req_last_in;
      end
      if (done) begin
         rsp_data_out <= cmd_ff ? key_word : '0;
         rsp_last_out <= last_ff;
      end
   end

   lxkc_ctrl #(.TABLE_WORDS(TABLE_WORDS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .command(lxkc_pkg::cmd_type'(req_command)),
      .dcmd(dcmd), .busy(busy), .done(done)
   );

   lxkc_datapath #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(dcmd), .seed(seed_ff),
      .data_word(data_ff), .key_word(key_word)
   );
endmodule

@@ hw/rtl/lxkc_checker.sv @@
// lxkc_checker: port-level assertions for the cipher, bound to the top level.
// Depends on lagged_xor_keystream_cipher ports only.
module lxkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_data_out
);
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("second item taken");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("result dropped");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept with result pending");
endmodule

bind lagged_xor_keystream_cipher lxkc_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data_out(rsp_data_out)
);

@@ test/lagged_xor_keystream_cipher_tb.sv @@
// Testbench for lagged_xor_keystream_cipher: directed and random items checked
// against a key table predictor. Depends on lxkc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module lagged_xor_keystream_cipher_tb;
   localparam int KEY_WORDS  = 521;
   localparam int IDLE_LIMIT = 40000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      logic [31:0] data;
      logic        last;
   } cipher_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_key_seed = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [31:0] req_data_word = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_data_out;
   logic        rsp_last_out;

   logic [31:0]     key_words [KEY_WORDS];
   int              key_ptr = KEY_WORDS - 1;
   logic [31:0]     seed_shadow = '0;
   cipher_word_type pending_words[$];
   int              error_count = 0;
   int              idle_cycles = 0;
   int              hold_left = 0;
   bit              hold_request = 0;
   bit              no_idle = 0;

   lagged_xor_keystream_cipher uut (.*);

   always #5 clock = ~clock;

   function automatic void mix_keys();
      for (int i = 0; i < 32; i++) key_words[i] ^= key_words[i + 489];
      for (int i = 32; i < KEY_WORDS; i++) key_words[i] ^= key_words[i - 32];
      key_ptr = 0;
   endfunction

   function automatic void rebuild_keys();
      logic [31:0] s, acc;
      s = seed_shadow;
      acc = '0;
      for (int i = 0; i < 17; i++) begin
         for (int b = 0; b < 32; b++) begin
            s = s * lxkc_pkg::LCG_MUL + 32'd1;
            acc = (acc >> 1) | (s & 32'h80000000);
         end
         key_words[i] = acc;
      end
      key_words[16] = (key_words[0] >> 9) ^ (key_words[16] << 23) ^ key_words[15];
      for (int i = 17; i < KEY_WORDS; i++)
         key_words[i] = key_words[i-1] ^ ((key_words[i-17] << 23) & lxkc_pkg::HI_MASK)
                        ^ ((key_words[i-16] >> 9) & lxkc_pkg::LO_MASK);
      mix_keys();
      mix_keys();
      mix_keys();
      key_ptr = KEY_WORDS - 1;
   endfunction

   function automatic cipher_word_type cipher_predict(lxkc_pkg::cmd_type cmd,
                                                      logic [31:0] data, logic last);
      cipher_word_type w;
      w.last = last;
      w.data = '0;
      if (cmd == lxkc_pkg::CMD_REBUILD) begin
         rebuild_keys();
      end else begin
         key_ptr++;
         if (key_ptr >= KEY_WORDS) mix_keys();
         w.data = data ^ key_words[key_ptr];
      end
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic rand_last();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_item(lxkc_pkg::cmd_type cmd, logic [31:0] data, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_word <= data;
      req_last_in   <= last;
      do @(posedge clock); while (req_stall);
      pending_words.push_back(cipher_predict(cmd, data, last));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] seed);
      wait_drained();
      csr_valid    <= 1'b1;
      csr_key_seed <= seed;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_shadow = seed;
   endtask

   // receiver: checks each result item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected item", rsp_data_out, '0);
         end else begin
            cipher_word_type w;
            w = pending_words.pop_front();
            if (rsp_data_out !== w.data) report_mismatch("data_out", rsp_data_out, w.data);
            if (rsp_last_out !== w.last)
               report_mismatch("last_out", {31'd0, rsp_last_out}, {31'd0, w.last});
         end
      end
   end

   always @(posedge clock) begin
      int r;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (no_idle || r < 65) rsp_stall <= 1'b0;
         else if (r < 95) begin
            hold_left <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            hold_left <= $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_edge_words();
      write_seed(32'h0);
      send_item(lxkc_pkg::CMD_REBUILD, 32'hFFFFFFFF, 1'b1);
      send_item(lxkc_pkg::CMD_CRYPT, 32'h00000000, 1'b0);
      send_item(lxkc_pkg::CMD_CRYPT, 32'hFFFFFFFF, 1'b1);
      send_item(lxkc_pkg::CMD_CRYPT, 32'h55555555, 1'b0);
      send_item(lxkc_pkg::CMD_CRYPT, 32'hAAAAAAAA, 1'b1);
      write_seed(32'hFFFFFFFF);
      send_item(lxkc_pkg::CMD_REBUILD, 32'h0, 1'b0);
      send_item(lxkc_pkg::CMD_REBUILD, 32'h12345678, 1'b1);
      for (int i = 0; i < 8; i++)
         send_item(lxkc_pkg::CMD_CRYPT, 32'h1 << (i * 4), i[0]);
   endtask

   task automatic test_back_to_back();
      no_idle = 1;
      for (int i = 0; i < 80; i++) send_item(lxkc_pkg::CMD_CRYPT, $urandom, rand_last());
      no_idle = 0;
   endtask

   task automatic test_long_hold();
      hold_request = 1;
      for (int i = 0; i < 60; i++) send_item(lxkc_pkg::CMD_CRYPT, $urandom, rand_last());
      wait_drained();
   endtask

   // long run without rebuild so the pointer wraps and the table is remixed
   task automatic test_table_wrap();
      write_seed($urandom);
      send_item(lxkc_pkg::CMD_REBUILD, $urandom, 1'b0);
      for (int i = 0; i < 560; i++) send_item(lxkc_pkg::CMD_CRYPT, $urandom, rand_last());
   endtask

   task automatic test_mixed_commands();
      write_seed($urandom);
      send_item(lxkc_pkg::CMD_REBUILD, $urandom, 1'b1);
      for (int i = 0; i < 60; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_item(lxkc_pkg::CMD_REBUILD, $urandom, rand_last());
         else send_item(lxkc_pkg::CMD_CRYPT, $urandom, rand_last());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_edge_words();
      test_back_to_back();
      test_long_hold();
      test_table_wrap();
      test_mixed_commands();
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/lxkc_pkg.sv
hw/rtl/lxkc_datapath.sv
hw/rtl/lxkc_ctrl.sv
hw/rtl/lagged_xor_keystream_cipher.sv
hw/rtl/lxkc_checker.sv
test/lagged_xor_keystream_cipher_tb.sv
